### rtl/core/spectrum_bar_delta_renderer_defines.svh
// Assertion macros for the spectrum bar delta renderer.
// Included by the top level; depends on nothing else.
`ifndef SPECTRUM_BAR_DELTA_RENDERER_DEFINES_SVH
`define SPECTRUM_BAR_DELTA_RENDERER_DEFINES_SVH
`ifndef SYNTH
`define SBDR_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SBDR_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define SBDR_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define SBDR_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

### rtl/core/sbdr_pkg.sv
// Shared types and constants of the spectrum bar delta renderer.
// No dependencies.
`timescale 1ns / 1ps
package sbdr_pkg;
    localparam logic [2:0] CFG_BAR_COUNT     = 3'd0;
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_TOP_MARGIN    = 3'd3;
    localparam logic [2:0] CFG_LOW_COLOR     = 3'd4;
    localparam logic [2:0] CFG_MID_COLOR     = 3'd5;
    localparam logic [2:0] CFG_HIGH_COLOR    = 3'd6;
    localparam logic [15:0] WHITE = 16'hFFFF;
    localparam logic [15:0] BLACK = 16'h0000;
    localparam logic [20:0] LOG_SCALE_Q16 = 21'd1676906;
    localparam logic [30:0] SUM_MAX = 31'h7FFFFFFF;

    typedef struct packed {
        logic        draw_kind;
        logic [9:0]  x_pos;
        logic [9:0]  y_pos;
        logic [9:0]  rect_width;
        logic [9:0]  rect_height;
        logic [15:0] color;
        logic        last_command;
    } cmd_t;

    typedef struct packed {
        logic        start;
        logic [31:0] value;
    } log_req_t;

    typedef struct packed {
        logic        done;
        logic [20:0] result;
    } log_rsp_t;
endpackage

### rtl/core/sbdr_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sbdr_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/sbdr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but itself.
`timescale 1ns / 1ps
module sbdr_div #(
    parameter int NW = 31,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [DW:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DW-1:0], quo_reg[NW-1]};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

### rtl/core/sbdr_log.sv
// Iterative log2 unit: leading one search, then one squaring per cycle,
// scaled to the bar height. Uses sbdr_pkg.
`timescale 1ns / 1ps
module sbdr_log
    import sbdr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  log_req_t req,
    output log_rsp_t rsp
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NORM = 3'd1;
    localparam logic [2:0] S_SQR  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  st_reg, st_next;
    logic [31:0] v_reg, v_next;
    logic [4:0]  p_reg, p_next;
    logic [16:0] x_reg, x_next;
    logic [15:0] frac_reg, frac_next;
    logic [4:0]  it_reg, it_next;
    logic [52:0] prod_reg, prod_next;
    logic [4:0]  lead;
    logic [33:0] sq;
    logic [20:0] lq;
    logic        done_next;
    logic        done_reg;

    always_comb
    begin
        lead = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (v_reg[i])
            begin
                lead = 5'(i);
            end
        end
    end

    assign sq = 34'(x_reg) * 34'(x_reg);
    assign lq = (p_reg < 5'd8) ? 21'd0 : {p_reg - 5'd8, frac_reg};

    always_comb
    begin
        st_next   = st_reg;
        v_next    = v_reg;
        p_next    = p_reg;
        x_next    = x_reg;
        frac_next = frac_reg;
        it_next   = it_reg;
        prod_next = prod_reg;
        done_next = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    v_next  = req.value;
                    st_next = S_NORM;
                end
            end
            S_NORM:
            begin
                p_next    = lead;
                x_next    = (lead >= 5'd15) ? 17'(v_reg >> (lead - 5'd15))
                                            : 17'(v_reg << (5'd15 - lead));
                frac_next = '0;
                it_next   = 5'd0;
                st_next   = S_SQR;
            end
            S_SQR:
            begin
                if (sq[31:15] >= 17'h10000)
                begin
                    x_next = 17'(sq[31:16]);
                    frac_next[4'd15 - it_reg[3:0]] = 1'b1;
                end
                else
                begin
                    x_next = sq[31:15];
                end
                it_next = it_reg + 1'b1;
                if (it_reg == 5'd15)
                begin
                    st_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next = 53'(lq) * 53'(LOG_SCALE_Q16);
                st_next   = S_OUT;
            end
            S_OUT:
            begin
                done_next = 1'b1;
                st_next   = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        p_reg    <= p_next;
        x_reg    <= x_next;
        frac_reg <= frac_next;
        it_reg   <= it_next;
        prod_reg <= prod_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = prod_reg[52:32];
endmodule

### rtl/core/spectrum_bar_delta_renderer.sv
// Spectrum bar renderer with delta drawing: top level, sequencer and output stage.
// Uses sbdr_pkg, sbdr_ram, sbdr_div, sbdr_log and the assertion macro header.
`timescale 1ns / 1ps
`include "spectrum_bar_delta_renderer_defines.svh"
// One bin is taken at a time, in the idle state. For a bin that is not a
// group's last, two divides form the bins per bar and the bar width, while the
// bar and the offset within it are stepped out by repeated subtraction. A bin
// outside every group is dropped once the bins per bar are known. For a group's
// last bin a further divide forms the mean, a log unit squares the mantissa once
// a cycle, the bar's stored height is read from and written back to a small RAM,
// and up to two commands leave through the output register. The stored heights
// are cleared by a pass over every entry (32 entries by default) after reset,
// during which no bin is taken.
// Configuration writes are taken at any time and should be made only while no
// bin is in flight.
module spectrum_bar_delta_renderer
    import sbdr_pkg::*;
#(
    parameter int MAX_BARS = 32,
    parameter int BAR_BINS = 128,
    parameter int FFT_BINS = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // bin_index[8:0], magnitude[32:9], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // x_pos, y_pos, rect_width, rect_height, color
    output logic        m_tuser,  // draw_kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    localparam int LIM = (MAX_BARS < BAR_BINS) ? MAX_BARS : BAR_BINS;
    localparam int AW  = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
    localparam int BW  = $clog2(BAR_BINS + 1);
    localparam int BCW = $clog2(LIM + 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_BIN   = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_LOG   = 4'd4;
    localparam logic [3:0] S_PREP  = 4'd5;
    localparam logic [3:0] S_CMD0  = 4'd6;
    localparam logic [3:0] S_CMD1  = 4'd7;

    logic [5:0]  bar_count_reg;
    logic [9:0]  screen_width_reg, screen_height_reg;
    logic [7:0]  top_margin_reg;
    logic [15:0] low_color_reg, mid_color_reg, high_color_reg;

    logic [3:0]  st_reg, st_next;
    logic [AW:0] clr_reg, clr_next;
    logic [30:0] sum_reg, sum_next;
    logic [8:0]  idx_reg, idx_next;
    logic [23:0] mag_reg, mag_next;
    logic [BCW-1:0] bc_reg, bc_next;
    logic [BW-1:0]  bpb_reg, bpb_next;
    logic [AW-1:0]  bar_reg, bar_next;
    logic [BW-1:0]  k_reg, k_next;
    logic [9:0]  h_reg, h_next;
    logic [9:0]  prev_reg, prev_next;
    logic [9:0]  barw_reg, barw_next;
    logic [15:0] col_reg, col_next;
    cmd_t        out_reg, out_next;
    logic        ov_reg, ov_next;
    logic        wdone_reg, wdone_next;

    logic [BCW-1:0] bc_eff;
    logic [31:0] grouped;
    logic [31:0] sum_add;
    logic        div_start, div_done, wdiv_start, wdiv_done;
    logic [30:0] mean;
    logic [9:0]  barw_q;
    log_req_t    lreq;
    log_rsp_t    lrsp;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [9:0]  ram_wdata, ram_rdata;
    logic [9:0]  maxh, xpos, wdt;
    logic [20:0] hcap;
    logic [15:0] xprod;
    logic [15:0] bc_third, bc_two_thirds;
    logic        grow, shrink, cap;
    logic        out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_count_reg     <= 6'd32;
            screen_width_reg  <= 10'd320;
            screen_height_reg <= 10'd170;
            top_margin_reg    <= 8'd22;
            low_color_reg     <= 16'd63488;
            mid_color_reg     <= 16'd2016;
            high_color_reg    <= 16'd2047;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BAR_COUNT:     bar_count_reg     <= cfg_wdata[5:0];
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata[9:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata[9:0];
                CFG_TOP_MARGIN:    top_margin_reg    <= cfg_wdata[7:0];
                CFG_LOW_COLOR:     low_color_reg     <= cfg_wdata;
                CFG_MID_COLOR:     mid_color_reg     <= cfg_wdata;
                CFG_HIGH_COLOR:    high_color_reg    <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (bar_count_reg == 6'd0)
        begin
            bc_eff = BCW'(1);
        end
        else if (32'(bar_count_reg) > LIM)
        begin
            bc_eff = BCW'(LIM);
        end
        else
        begin
            bc_eff = BCW'(bar_count_reg);
        end
    end

    sbdr_div #(.NW(31), .DW(BW)) u_mean_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_next),
        .den   (bpb_reg),
        .done  (div_done),
        .quo   (mean)
    );

    // The bar width and the bins per bar share the same divider form.
    logic [30:0] wdiv_q;
    logic        bpb_phase_reg, bpb_phase_next;
    logic [30:0] wnum;
    logic [BW-1:0] wden;
    assign wnum = bpb_phase_reg ? 31'(BAR_BINS) : 31'(screen_width_reg);
    assign wden = BW'(bc_reg);
    sbdr_div #(.NW(31), .DW(BW)) u_cfg_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (wdiv_start),
        .num   (wnum),
        .den   (wden),
        .done  (wdiv_done),
        .quo   (wdiv_q)
    );
    assign barw_q = 10'(wdiv_q);

    sbdr_log u_log (
        .clk (clk),
        .rst_n (rst_n),
        .req (lreq),
        .rsp (lrsp)
    );

    sbdr_ram #(.WIDTH(10), .DEPTH(1 << AW)) u_heights (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (bar_reg),
        .rdata (ram_rdata)
    );

    assign grouped  = 32'(bpb_reg) * 32'(bc_reg);
    assign sum_add  = 32'(sum_reg) + 32'(mag_reg);
    assign maxh     = (screen_height_reg > 10'(top_margin_reg))
                    ? screen_height_reg - 10'(top_margin_reg) : 10'd0;
    assign hcap     = (lrsp.result > 21'(maxh)) ? 21'(maxh) : lrsp.result;
    assign xprod    = 16'(bar_reg) * 16'(barw_reg);
    assign xpos     = xprod[9:0];
    assign wdt      = (barw_reg == 10'd0) ? 10'd0 : barw_reg - 10'd1;
    assign grow     = h_reg > prev_reg;
    assign shrink   = h_reg < prev_reg;
    assign cap      = h_reg != 10'd0;
    assign out_free = !ov_reg || m_tready;
    assign s_tready = (st_reg == S_IDLE);

    // A third of the bar count by multiplying with 171/512, exact below 512.
    assign bc_third      = 16'((32'(bc_reg) * 32'd171) >> 9);
    assign bc_two_thirds = 16'((32'(bc_reg) * 32'd342) >> 9);

    // The bar width divide restarts for each item, taking bins per bar first.
    logic [1:0] cfgd_reg, cfgd_next;

    always_comb
    begin
        st_next        = st_reg;
        clr_next       = clr_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        mag_next       = mag_reg;
        bc_next        = bc_reg;
        bpb_next       = bpb_reg;
        bar_next       = bar_reg;
        k_next         = k_reg;
        h_next         = h_reg;
        prev_next      = prev_reg;
        barw_next      = barw_reg;
        col_next       = col_reg;
        out_next       = out_reg;
        ov_next        = ov_reg;
        wdone_next     = wdone_reg || wdiv_done;
        bpb_phase_next = bpb_phase_reg;
        cfgd_next      = cfgd_reg;
        div_start      = 1'b0;
        wdiv_start     = 1'b0;
        lreq.start     = 1'b0;
        lreq.value     = 32'd256 + 32'(mean) * 32'd5;
        ram_we         = 1'b0;
        ram_waddr      = bar_reg;
        ram_wdata      = h_reg;
        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg[AW-1:0];
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg[AW-1:0] == AW'((1 << AW) - 1))
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    idx_next       = s_tdata[8:0];
                    mag_next       = s_tdata[32:9];
                    bc_next        = bc_eff;
                    bpb_phase_next = 1'b1;
                    cfgd_next      = 2'd0;
                    st_next        = S_BIN;
                end
            end
            S_BIN:
            begin
                unique case (cfgd_reg)
                    2'd0:
                    begin
                        wdiv_start = 1'b1;
                        cfgd_next  = 2'd1;
                    end
                    2'd1:
                    begin
                        if (wdiv_done)
                        begin
                            bpb_next       = BW'(wdiv_q);
                            bpb_phase_next = 1'b0;
                            cfgd_next      = 2'd2;
                        end
                    end
                    2'd2:
                    begin
                        cfgd_next = 2'd3;
                        if (idx_reg == 9'd0 || 32'(idx_reg) > grouped
                            || 32'(idx_reg) >= FFT_BINS)
                        begin
                            st_next = S_IDLE;
                        end
                        else
                        begin
                            wdiv_start = 1'b1;
                            wdone_next = 1'b0;
                            bar_next   = '0;
                            k_next     = BW'(idx_reg - 9'd1);
                        end
                    end
                    default:
                    begin
                        // Step bar and offset by repeated subtraction.
                        if (32'(k_reg) >= 32'(bpb_reg))
                        begin
                            k_next   = k_reg - bpb_reg;
                            bar_next = bar_reg + 1'b1;
                        end
                        else if (wdiv_done || wdone_reg)
                        begin
                            barw_next = barw_q;
                            if (k_reg == BW'(0))
                            begin
                                sum_next = 31'(mag_reg);
                            end
                            else
                            begin
                                sum_next = sum_add[31] ? SUM_MAX : sum_add[30:0];
                            end
                            if (k_reg != bpb_reg - 1'b1)
                            begin
                                st_next = S_IDLE;
                            end
                            else
                            begin
                                div_start = 1'b1;
                                st_next   = S_DIV;
                            end
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    lreq.start = 1'b1;
                    sum_next   = '0;
                    st_next    = S_LOG;
                end
            end
            S_LOG:
            begin
                if (lrsp.done)
                begin
                    h_next = hcap[9:0];
                    if (16'(bar_reg) < bc_third)
                    begin
                        col_next = low_color_reg;
                    end
                    else if (16'(bar_reg) < bc_two_thirds)
                    begin
                        col_next = mid_color_reg;
                    end
                    else
                    begin
                        col_next = high_color_reg;
                    end
                    st_next = S_PREP;
                end
            end
            S_PREP:
            begin
                prev_next = ram_rdata;
                ram_we    = 1'b1;
                st_next   = S_CMD0;
            end
            S_CMD0:
            begin
                if (!grow && !shrink)
                begin
                    st_next = S_IDLE;
                end
                else if (out_free)
                begin
                    ov_next              = 1'b1;
                    out_next.draw_kind   = 1'b0;
                    out_next.x_pos       = xpos;
                    out_next.rect_width  = wdt;
                    if (grow)
                    begin
                        out_next.y_pos        = screen_height_reg - h_reg;
                        out_next.rect_height  = (prev_reg == 10'd0) ? h_reg
                                              : h_reg - prev_reg + 10'd1;
                        out_next.color        = col_reg;
                        out_next.last_command = 1'b0;
                        st_next               = S_CMD1;
                    end
                    else
                    begin
                        out_next.y_pos = (prev_reg > screen_height_reg) ? 10'd0
                                       : screen_height_reg - prev_reg;
                        out_next.rect_height  = prev_reg - h_reg;
                        out_next.color        = BLACK;
                        out_next.last_command = !cap;
                        st_next               = cap ? S_CMD1 : S_IDLE;
                    end
                end
            end
            S_CMD1:
            begin
                if (out_free)
                begin
                    ov_next               = 1'b1;
                    out_next.draw_kind    = 1'b1;
                    out_next.x_pos        = xpos;
                    out_next.y_pos        = screen_height_reg - h_reg;
                    out_next.rect_width   = wdt;
                    out_next.rect_height  = 10'd1;
                    out_next.color        = WHITE;
                    out_next.last_command = 1'b1;
                    st_next               = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_CLEAR;
            clr_reg   <= '0;
            sum_reg   <= '0;
            ov_reg    <= 1'b0;
            wdone_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            clr_reg   <= clr_next;
            sum_reg   <= sum_next;
            ov_reg    <= ov_next;
            wdone_reg <= wdone_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        mag_reg       <= mag_next;
        bc_reg        <= bc_next;
        bpb_reg       <= bpb_next;
        bar_reg       <= bar_next;
        k_reg         <= k_next;
        h_reg         <= h_next;
        prev_reg      <= prev_next;
        barw_reg      <= barw_next;
        col_reg       <= col_next;
        out_reg       <= out_next;
        bpb_phase_reg <= bpb_phase_next;
        cfgd_reg      <= cfgd_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = out_reg.last_command;
    assign m_tuser  = out_reg.draw_kind;
    assign m_tdata  = {out_reg.color, out_reg.rect_height, out_reg.rect_width,
                       out_reg.y_pos, out_reg.x_pos};

    `SBDR_ASSERT_IMPL(a_no_take_busy, clk, rst_n, st_reg != S_IDLE, !s_tready,
        "item taken while busy")
    `SBDR_ASSERT_NEXT(a_cap_last, clk, rst_n, st_reg == S_CMD1 && out_free,
        m_tvalid && m_tlast, "cap command is not the last")
    `SBDR_ASSERT_IMPL(a_clear_quiet, clk, rst_n, st_reg == S_CLEAR, !m_tvalid,
        "output during clear")
endmodule

### bench/spectrum_bar_delta_renderer_checker.sv
// Checker of the spectrum bar delta renderer: predicts the draw commands from the
// accepted bin requests and configuration writes, and compares them. Uses sbdr_pkg.
`timescale 1ns / 1ps
module spectrum_bar_delta_renderer_checker
    import sbdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          fails,
    output int          pending,
    output int          cmds_checked
);
    logic [5:0]  bar_cnt;
    logic [9:0]  scr_w;
    logic [9:0]  scr_h;
    logic [7:0]  margin;
    logic [15:0] col_low;
    logic [15:0] col_mid;
    logic [15:0] col_high;
    logic [31:0] group_sum;
    logic [9:0]  bar_height [32];
    cmd_t        draw_queue [$];

    assign pending = draw_queue.size();

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fails++;
    endtask

    function automatic logic [20:0] log2_minus8(input logic [31:0] v);
        int          p;
        logic [63:0] x;
        logic [15:0] frac;
        p = 31;
        frac = '0;
        while (p > 0 && v[p] == 1'b0)
            p--;
        if (p >= 15)
            x = 64'(v >> (p - 15));
        else
            x = 64'(v) << (15 - p);
        for (int i = 15; i >= 0; i--)
        begin
            x = (x * x) >> 15;
            if (x >= 64'h10000)
            begin
                x = x >> 1;
                frac[i] = 1'b1;
            end
        end
        if (p < 8)
            return '0;
        return 21'(((p - 8) << 16) + frac);
    endfunction

    function automatic cmd_t make_cmd(input logic kind, input int x, input int y,
                                      input int w, input int h, input logic [15:0] c,
                                      input logic last);
        cmd_t cm;
        if (y < 0)
            y = 0;
        cm.draw_kind = kind;
        cm.x_pos = 10'(x);
        cm.y_pos = 10'(y);
        cm.rect_width = 10'(w);
        cm.rect_height = 10'(h);
        cm.color = c;
        cm.last_command = last;
        return cm;
    endfunction

    task automatic predict_bin(input logic [8:0] idx, input logic [23:0] mag);
        int          bc;
        int          bpb;
        int          b;
        int          k;
        int          h;
        int          maxh;
        int          prev;
        int          bar_w;
        int          x;
        int          w;
        logic [31:0] mean;
        logic [63:0] prod;
        logic [15:0] c;
        bc = (bar_cnt == 0) ? 1 : (bar_cnt > 32 ? 32 : int'(bar_cnt));
        bpb = 128 / bc;
        if (idx == 0 || idx > bpb * bc)
            return;
        b = (idx - 1) / bpb;
        k = (idx - 1) % bpb;
        if (k == 0)
            group_sum = 32'(mag);
        else if (group_sum > 32'(SUM_MAX) - 32'(mag))
            group_sum = 32'(SUM_MAX);
        else
            group_sum = group_sum + 32'(mag);
        if (k != bpb - 1)
            return;
        mean = group_sum / bpb;
        group_sum = '0;
        prod = 64'(log2_minus8(32'd256 + 32'd5 * mean)) * 64'(LOG_SCALE_Q16);
        h = int'(prod >> 32);
        maxh = (scr_h > margin) ? int'(scr_h) - int'(margin) : 0;
        if (h > maxh)
            h = maxh;
        bar_w = int'(scr_w) / bc;
        x = b * bar_w;
        w = (bar_w > 0) ? bar_w - 1 : 0;
        if (b < bc / 3)
            c = col_low;
        else if (b < 2 * bc / 3)
            c = col_mid;
        else
            c = col_high;
        prev = int'(bar_height[b]);
        bar_height[b] = 10'(h);
        if (h > prev)
        begin
            draw_queue.push_back(make_cmd(1'b0, x, int'(scr_h) - h, w,
                                          (prev == 0) ? h : h - prev + 1, c, 1'b0));
            draw_queue.push_back(make_cmd(1'b1, x, int'(scr_h) - h, w, 1, WHITE, 1'b1));
        end
        else if (h < prev)
        begin
            draw_queue.push_back(make_cmd(1'b0, x, int'(scr_h) - prev, w, prev - h,
                                          BLACK, (h > 0) ? 1'b0 : 1'b1));
            if (h > 0)
                draw_queue.push_back(make_cmd(1'b1, x, int'(scr_h) - h, w, 1, WHITE, 1'b1));
        end
    endtask

    task automatic check_cmd();
        cmd_t want;
        cmd_t got;
        got.draw_kind = m_tuser;
        got.x_pos = m_tdata[9:0];
        got.y_pos = m_tdata[19:10];
        got.rect_width = m_tdata[29:20];
        got.rect_height = m_tdata[39:30];
        got.color = m_tdata[55:40];
        got.last_command = m_tlast;
        cmds_checked++;
        if (draw_queue.size() == 0)
        begin
            report($sformatf("unexpected command %p", got));
            return;
        end
        want = draw_queue.pop_front();
        if (got.draw_kind != want.draw_kind)
            report($sformatf("draw_kind %0d, want %0d", got.draw_kind, want.draw_kind));
        if (got.x_pos != want.x_pos)
            report($sformatf("x_pos %0d, want %0d", got.x_pos, want.x_pos));
        if (got.y_pos != want.y_pos)
            report($sformatf("y_pos %0d, want %0d", got.y_pos, want.y_pos));
        if (got.rect_width != want.rect_width)
            report($sformatf("rect_width %0d, want %0d", got.rect_width, want.rect_width));
        if (got.rect_height != want.rect_height)
            report($sformatf("rect_height %0d, want %0d", got.rect_height, want.rect_height));
        if (got.color != want.color)
            report($sformatf("color %h, want %h", got.color, want.color));
        if (got.last_command != want.last_command)
            report($sformatf("last %0d, want %0d", got.last_command, want.last_command));
    endtask

    initial
    begin
        fails = 0;
        cmds_checked = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_cnt <= 6'd32;
            scr_w <= 10'd320;
            scr_h <= 10'd170;
            margin <= 8'd22;
            col_low <= 16'd63488;
            col_mid <= 16'd2016;
            col_high <= 16'd2047;
            group_sum = '0;
            for (int i = 0; i < 32; i++)
                bar_height[i] = '0;
            draw_queue.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_cmd();
            if (s_tvalid && s_tready)
                predict_bin(s_tdata[8:0], s_tdata[32:9]);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BAR_COUNT:     bar_cnt <= cfg_wdata[5:0];
                    CFG_SCREEN_WIDTH:  scr_w <= cfg_wdata[9:0];
                    CFG_SCREEN_HEIGHT: scr_h <= cfg_wdata[9:0];
                    CFG_TOP_MARGIN:    margin <= cfg_wdata[7:0];
                    CFG_LOW_COLOR:     col_low <= cfg_wdata;
                    CFG_MID_COLOR:     col_mid <= cfg_wdata;
                    CFG_HIGH_COLOR:    col_high <= cfg_wdata;
                    default:           ;
                endcase
            end
        end
    end
endmodule

### bench/spectrum_bar_delta_renderer_tb.sv
// Top of the spectrum bar delta renderer bench: clock, reset, bin stimulus,
// configuration phases and verdict. Uses sbdr_pkg and the checker module.
`timescale 1ns / 1ps
module spectrum_bar_delta_renderer_tb
    import sbdr_pkg::*;
();
    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    int          fails;
    int          pending;
    int          cmds_checked;
    int          send_idle;
    int          recv_idle;
    int          hold_cycles = 0;
    logic        hold_go;
    logic        hold_done = 1'b0;
    int          stall_count = 0;
    int          bins_sent;
    int          active_bars;

    spectrum_bar_delta_renderer dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    spectrum_bar_delta_renderer_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fails(fails), .pending(pending), .cmds_checked(cmds_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_go && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_cycles <= 1500;
                m_tready <= 1'b0;
            end
            else if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= 10000)
        begin
            $display("watchdog: no request moved for 10000 cycles");
            $display("spectrum_bar_delta_renderer test failed");
            $finish;
        end
    end

    task automatic send_bin(input logic [8:0] idx, input logic [23:0] mag);
        logic rdy;
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, mag, idx};
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end while (!rdy);
        bins_sent++;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic setup(input int bc, input int sw, input int sh, input int tm,
                         input logic [15:0] lo, input logic [15:0] mi,
                         input logic [15:0] hi);
        drain();
        write_reg(CFG_BAR_COUNT, 16'(bc));
        write_reg(CFG_SCREEN_WIDTH, 16'(sw));
        write_reg(CFG_SCREEN_HEIGHT, 16'(sh));
        write_reg(CFG_TOP_MARGIN, 16'(tm));
        write_reg(CFG_LOW_COLOR, lo);
        write_reg(CFG_MID_COLOR, mi);
        write_reg(CFG_HIGH_COLOR, hi);
        cfg_we <= 1'b0;
        @(posedge clk);
        active_bars = (bc == 0) ? 1 : (bc > 32 ? 32 : bc);
    endtask

    function automatic logic [23:0] pick_mag();
        case ($urandom_range(3))
            0: return 24'd0;
            1: return 24'($urandom_range(4095));
            2: return 24'($urandom);
            default: return 24'hFFFFFF - 24'($urandom_range(255));
        endcase
    endfunction

    task automatic run_frames(input int quota);
        int start;
        int span;
        start = bins_sent;
        span = (128 / active_bars) * active_bars;
        while (bins_sent - start < quota)
        begin
            for (int i = 1; i <= span && bins_sent - start < quota; i++)
            begin
                if ($urandom_range(99) < 8)
                    send_bin(9'($urandom_range(511)), 24'($urandom));
                else
                    send_bin(9'(i), pick_mag());
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_BAR_COUNT;
        cfg_wdata = '0;
        send_idle = 16;
        recv_idle = 74;
        hold_go = 1'b0;
        bins_sent = 0;
        active_bars = 32;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_bin(9'd0, 24'hFFFFFF);
        for (int i = 1; i <= 4; i++)
            send_bin(9'(i), 24'hFFFFFF);
        for (int i = 1; i <= 4; i++)
            send_bin(9'(i), 24'hFFFFFF);
        for (int i = 1; i <= 4; i++)
            send_bin(9'(i), 24'd0);
        for (int i = 1; i <= 4; i++)
            send_bin(9'(i), 24'h000100);
        for (int i = 5; i <= 8; i++)
            send_bin(9'(i), 24'hFFFFFF);
        for (int i = 5; i <= 8; i++)
            send_bin(9'(i), 24'h004000);
        send_bin(9'd129, 24'h123456);
        send_bin(9'd511, 24'hABCDEF);

        setup(8, 1023, 1023, 0, 16'h0000, 16'($urandom), 16'hFFFF);
        run_frames(40);
        setup(1, 8, 24, 255, 16'($urandom), 16'($urandom), 16'($urandom));
        run_frames(128);

        send_idle = 74;
        recv_idle = 16;
        setup(32, 8, 100, 10, 16'($urandom), 16'($urandom), 16'($urandom));
        run_frames(40);
        setup(0, 320, 500, 0, 16'($urandom), 16'($urandom), 16'($urandom));
        run_frames(128);

        send_idle = 0;
        recv_idle = 0;
        setup(40, 1000, 300, 22, 16'($urandom), 16'($urandom), 16'($urandom));
        hold_go = 1'b1;
        run_frames(40);
        setup(3, $urandom_range(1023, 8), $urandom_range(1023, 24), $urandom_range(255),
              16'($urandom), 16'($urandom), 16'($urandom));
        run_frames(40);
        setup(63, 320, 170, 22, 16'($urandom), 16'($urandom), 16'($urandom));
        run_frames(40);

        drain();
        $display("Summary: %0d bins sent over eight register settings, %0d draw commands checked.",
                 bins_sent, cmds_checked);
        if (fails == 0)
            $display("spectrum_bar_delta_renderer test passed");
        else
            $display("spectrum_bar_delta_renderer test failed");
        $finish;
    end
endmodule
